// ----- design/msie_pkg.sv -----
// ----------------------------------------------------------------------------
// MIPS subset executor package
// Item types, opcode and function codes shared by the executor.
// ----------------------------------------------------------------------------
`default_nettype none
package msie_pkg;

    typedef enum logic [1:0] {
        REQ_EXEC    = 2'd0,
        REQ_PRELOAD = 2'd1,
        REQ_RESTART = 2'd2,
        REQ_NONE    = 2'd3
    } req_type_t;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [31:0] instr_word;
        logic [9:0]  load_address;
        logic [7:0]  load_byte;
    } in_item_t;

    typedef struct packed {
        logic [31:0] next_pc;
        logic        reg_changed;
        logic [4:0]  reg_index;
        logic [31:0] reg_value;
        logic [31:0] hi_value;
        logic [31:0] lo_value;
        logic        err_write_zero;
        logic        err_overflow;
        logic        err_overwrite_hilo;
        logic        err_misaligned;
        logic        err_address;
        logic        halted;
    } out_item_t;

    localparam logic [0:0] CFG_START_PC = 1'd0;
    localparam logic [0:0] CFG_INIT_SP  = 1'd1;

    localparam logic [5:0] OP_SPECIAL = 6'd0;
    localparam logic [5:0] OP_J     = 6'd2;
    localparam logic [5:0] OP_JAL   = 6'd3;
    localparam logic [5:0] OP_BEQ   = 6'd4;
    localparam logic [5:0] OP_BNE   = 6'd5;
    localparam logic [5:0] OP_BGTZ  = 6'd7;
    localparam logic [5:0] OP_ADDI  = 6'd8;
    localparam logic [5:0] OP_ADDIU = 6'd9;
    localparam logic [5:0] OP_SLTI  = 6'd10;
    localparam logic [5:0] OP_ANDI  = 6'd12;
    localparam logic [5:0] OP_ORI   = 6'd13;
    localparam logic [5:0] OP_NORI  = 6'd14;
    localparam logic [5:0] OP_LUI   = 6'd16;
    localparam logic [5:0] OP_LB    = 6'd32;
    localparam logic [5:0] OP_LH    = 6'd33;
    localparam logic [5:0] OP_LW    = 6'd35;
    localparam logic [5:0] OP_LBU   = 6'd36;
    localparam logic [5:0] OP_LHU   = 6'd37;
    localparam logic [5:0] OP_SB    = 6'd40;
    localparam logic [5:0] OP_SH    = 6'd41;
    localparam logic [5:0] OP_SW    = 6'd43;
    localparam logic [5:0] OP_HALT  = 6'd63;

    localparam logic [5:0] FN_SLL   = 6'd0;
    localparam logic [5:0] FN_SRL   = 6'd2;
    localparam logic [5:0] FN_SRA   = 6'd3;
    localparam logic [5:0] FN_JR    = 6'd8;
    localparam logic [5:0] FN_MFHI  = 6'd16;
    localparam logic [5:0] FN_MFLO  = 6'd18;
    localparam logic [5:0] FN_MULT  = 6'd24;
    localparam logic [5:0] FN_MULTU = 6'd25;
    localparam logic [5:0] FN_ADD   = 6'd32;
    localparam logic [5:0] FN_ADDU  = 6'd33;
    localparam logic [5:0] FN_SUB   = 6'd34;
    localparam logic [5:0] FN_AND   = 6'd36;
    localparam logic [5:0] FN_OR    = 6'd37;
    localparam logic [5:0] FN_XOR   = 6'd38;
    localparam logic [5:0] FN_NOR   = 6'd39;
    localparam logic [5:0] FN_NAND  = 6'd40;
    localparam logic [5:0] FN_SLT   = 6'd42;

    localparam logic [4:0] REG_SP = 5'd29;
    localparam logic [4:0] REG_RA = 5'd31;

endpackage
`default_nettype wire

// ----- design/mips_subset_instruction_executor_unit.sv -----
// ----------------------------------------------------------------------------
// MIPS subset instruction executor
// Executes one instruction, preload or restart item per clock while the input
// is not stalled, and reports the architectural effect of each item.
// ----------------------------------------------------------------------------
// An item is accepted whenever the result register is free and no load is
// completing, and its result is captured in the result register as it is
// accepted, so items follow back to back while the output is not stalled. A
// stalled result holds the input stalled. Every item except a load that
// reaches the data memory completes as it is accepted (register read, ALU or
// 32x32 multiply, store and write-back). A load that passes its address
// checks and targets a register other than zero completes later: the
// addressed memory row is captured in a register at the accepting edge, and
// in the next cycle the loaded value is written back and the result becomes
// valid; the input is stalled meanwhile. The register file, HI/LO and data
// memory each see at most one update per item. The data memory holds
// DATA_BYTES bytes as four byte-wide banks so that a word access touches one
// row of each bank. Bytes never written read as undefined.
`default_nettype none
module mips_subset_instruction_executor_unit
    import msie_pkg::*;
#(
    parameter int DATA_BYTES = 1024
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire in_item_t    in_data,
    output logic             out_valid,
    input  wire logic        out_stall,
    output out_item_t        out_data,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);

    localparam int RowBits = $clog2(DATA_BYTES / 4);
    localparam int AddrBits = RowBits + 2;
    localparam int Rows = DATA_BYTES / 4;

    logic [31:0] gpr_reg [32];
    logic [31:0] hi_reg, lo_reg, pc_reg, start_pc_reg, init_sp_reg;
    logic        unread_reg, stopped_reg;
    logic [7:0]  mem_reg [4][Rows];

    logic        out_valid_reg;
    out_item_t   out_reg;
    logic        accept;
    logic        load_pend_reg;

    // Decoded fields.
    logic [5:0]  op, fn;
    logic [4:0]  rs, rt, rd, sh;
    logic [31:0] a, b, imm, simm, pc4;
    assign op   = in_data.instr_word[31:26];
    assign rs   = in_data.instr_word[25:21];
    assign rt   = in_data.instr_word[20:16];
    assign rd   = in_data.instr_word[15:11];
    assign sh   = in_data.instr_word[10:6];
    assign fn   = in_data.instr_word[5:0];
    assign imm  = {16'd0, in_data.instr_word[15:0]};
    assign simm = {{16{in_data.instr_word[15]}}, in_data.instr_word[15:0]};
    assign a    = gpr_reg[rs];
    assign b    = gpr_reg[rt];
    assign pc4  = pc_reg + 32'd4;

    assign in_stall  = load_pend_reg || (out_valid_reg && out_stall);
    assign accept    = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // Address computation for loads and stores.
    logic [31:0] tgt, tgt_end;
    logic [2:0]  size;
    logic        is_load, is_store, mem_ok;
    logic        mis, adr, mem_ov;
    logic [32:0] end_ext;
    always_comb
    begin
        is_load  = (op == OP_LB) || (op == OP_LH) || (op == OP_LW) ||
                   (op == OP_LBU) || (op == OP_LHU);
        is_store = (op == OP_SB) || (op == OP_SH) || (op == OP_SW);
        if (op == OP_LW || op == OP_SW)
            size = 3'd4;
        else if (op == OP_LH || op == OP_LHU || op == OP_SH)
            size = 3'd2;
        else
            size = 3'd1;
        tgt     = a + simm;
        tgt_end = tgt + {29'd0, size} - 32'd1;
        end_ext = {1'b0, tgt} + {30'd0, size} - 33'd1;
        mem_ov  = (~(a[31] ^ simm[31]) & (a[31] ^ tgt[31])) ||
                  (size != 3'd1 && (~(a[31] ^ simm[31]) & (a[31] ^ tgt_end[31])));
        mis = ((size == 3'd4) && tgt[1:0] != 2'b00) || ((size == 3'd2) && tgt[0]);
        adr = tgt[31] || (end_ext >= 33'(DATA_BYTES));
        mem_ok = !mis && !adr;
    end

    // Row of each bank that holds the addressed word.
    logic [RowBits-1:0] row;
    logic [31:0]        pl_addr;
    assign row     = tgt[AddrBits-1:2];
    assign pl_addr = {22'd0, in_data.load_address};

    // Multiplier.
    logic [63:0] prod_s, prod_u;
    assign prod_s = 64'($signed(a) * $signed(b));
    assign prod_u = a * b;

    // Execute.
    logic [31:0] val, npc, off, br;
    logic        has_dest, wz, ov, ow, take, mul, rd_hilo, halt;
    logic [4:0]  dest;
    logic [63:0] prod;
    always_comb
    begin
        val = 32'd0; npc = pc4; has_dest = 1'b0; dest = rd;
        wz = 1'b0; ov = 1'b0; ow = 1'b0; take = 1'b0;
        mul = 1'b0; rd_hilo = 1'b0; halt = 1'b0;
        prod = prod_u;
        off = {simm[29:0], 2'b00};
        br  = pc4 + off;
        if (op == OP_HALT)
        begin
            halt = 1'b1;
            npc  = pc_reg;
        end
        else if (op == OP_SPECIAL)
        begin
            unique case (fn)
                FN_ADD:  begin val = a + b; has_dest = 1'b1;
                         ov = ~(a[31] ^ b[31]) & (a[31] ^ val[31]); end
                FN_ADDU: begin val = a + b; has_dest = 1'b1; end
                FN_SUB:  begin val = a - b; has_dest = 1'b1;
                         ov = (a[31] ^ b[31]) & (a[31] ^ val[31]); end
                FN_AND:  begin val = a & b; has_dest = 1'b1; end
                FN_OR:   begin val = a | b; has_dest = 1'b1; end
                FN_XOR:  begin val = a ^ b; has_dest = 1'b1; end
                FN_NOR:  begin val = ~(a | b); has_dest = 1'b1; end
                FN_NAND: begin val = ~(a & b); has_dest = 1'b1; end
                FN_SLT:  begin val = {31'd0, $signed(a) < $signed(b)}; has_dest = 1'b1; end
                FN_SLL:  begin val = b << sh; has_dest = !(sh == 5'd0 && rd == 5'd0); end
                FN_SRL:  begin val = b >> sh; has_dest = 1'b1; end
                FN_SRA:  begin val = $signed(b) >>> sh; has_dest = 1'b1; end
                FN_JR:   npc = a;
                FN_MULT: begin mul = 1'b1; prod = prod_s; ow = unread_reg; end
                FN_MULTU: begin mul = 1'b1; ow = unread_reg; end
                FN_MFHI: begin val = hi_reg; has_dest = 1'b1; rd_hilo = 1'b1; end
                FN_MFLO: begin val = lo_reg; has_dest = 1'b1; rd_hilo = 1'b1; end
                default: ;
            endcase
        end
        else
        begin
            dest = rt;
            if (is_load || is_store)
                ov = mem_ov;
            // A load writes back in the next cycle; a load aimed at register
            // zero is flagged whether or not its address is good.
            if (is_load)
                wz = (rt == 5'd0);
            unique case (op)
                OP_ADDI:  begin val = a + simm; has_dest = 1'b1;
                          ov = ~(a[31] ^ simm[31]) & (a[31] ^ val[31]); end
                OP_ADDIU: begin val = a + simm; has_dest = 1'b1; end
                OP_LUI:   begin val = {imm[15:0], 16'd0}; has_dest = 1'b1; end
                OP_ANDI:  begin val = a & imm; has_dest = 1'b1; end
                OP_ORI:   begin val = a | imm; has_dest = 1'b1; end
                OP_NORI:  begin val = ~(a | imm); has_dest = 1'b1; end
                OP_SLTI:  begin val = {31'd0, $signed(a) < $signed(simm)}; has_dest = 1'b1; end
                OP_BEQ:   take = (a == b);
                OP_BNE:   take = (a != b);
                OP_BGTZ:  take = !a[31] && (a != 32'd0);
                OP_J:     npc = {pc4[31:28], in_data.instr_word[25:0], 2'b00};
                OP_JAL:   begin
                              val = pc4; has_dest = 1'b1; dest = REG_RA;
                              npc = {pc4[31:28], in_data.instr_word[25:0], 2'b00};
                          end
                default: ;
            endcase
            if (take)
            begin
                npc = br;
                ov  = ~(pc4[31] ^ off[31]) & (pc4[31] ^ br[31]);
            end
        end
        if (has_dest && dest == 5'd0)
        begin
            wz = 1'b1;
            has_dest = 1'b0;
        end
    end

    logic exec, do_store, fault, ld_go;
    assign exec     = accept && in_data.req_type == REQ_EXEC && !stopped_reg;
    assign fault    = (is_load || is_store) && op != OP_SPECIAL && !mem_ok;
    assign do_store = exec && is_store && mem_ok;
    assign ld_go    = exec && is_load && mem_ok && rt != 5'd0;

    // Load completion: the captured row is aligned and extended by access type.
    logic [31:0] ld_word_reg;
    logic [5:0]  ld_op_reg;
    logic [1:0]  ld_lane_reg;
    logic [4:0]  ld_rt_reg;
    logic [7:0]  lane;
    logic [31:0] ld_val;
    logic        ld_changed;
    always_comb
    begin
        case (ld_lane_reg)
            2'd0: lane = ld_word_reg[31:24];
            2'd1: lane = ld_word_reg[23:16];
            2'd2: lane = ld_word_reg[15:8];
            default: lane = ld_word_reg[7:0];
        endcase
        unique case (ld_op_reg)
            OP_LB:  ld_val = {{24{lane[7]}}, lane};
            OP_LBU: ld_val = {24'd0, lane};
            OP_LH:  ld_val = ld_lane_reg[1] ?
                             {{16{ld_word_reg[15]}}, ld_word_reg[15:0]} :
                             {{16{ld_word_reg[31]}}, ld_word_reg[31:16]};
            OP_LHU: ld_val = ld_lane_reg[1] ? {16'd0, ld_word_reg[15:0]} :
                                              {16'd0, ld_word_reg[31:16]};
            default: ld_val = ld_word_reg;
        endcase
    end
    assign ld_changed = gpr_reg[ld_rt_reg] != ld_val;

    // Architectural state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 32; i++)
                gpr_reg[i] <= 32'd0;
            hi_reg <= 32'd0; lo_reg <= 32'd0; pc_reg <= 32'd0;
            unread_reg <= 1'b0; stopped_reg <= 1'b0;
            start_pc_reg <= 32'd0; init_sp_reg <= 32'd0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_START_PC)
                    start_pc_reg <= cfg_data;
                else
                    init_sp_reg <= cfg_data;
            end
            if (accept && in_data.req_type == REQ_RESTART)
            begin
                for (int i = 0; i < 32; i++)
                    gpr_reg[i] <= 32'd0;
                gpr_reg[REG_SP] <= init_sp_reg;
                hi_reg <= 32'd0; lo_reg <= 32'd0;
                unread_reg <= 1'b0; stopped_reg <= 1'b0;
                pc_reg <= start_pc_reg;
            end
            else if (exec)
            begin
                if (has_dest)
                    gpr_reg[dest] <= val;
                if (mul)
                begin
                    hi_reg <= prod[63:32];
                    lo_reg <= prod[31:0];
                    unread_reg <= 1'b1;
                end
                else if (rd_hilo)
                    unread_reg <= 1'b0;
                if (halt || fault)
                    stopped_reg <= 1'b1;
                pc_reg <= npc;
            end
            else if (load_pend_reg)
                gpr_reg[ld_rt_reg] <= ld_val;
        end
    end

    // Data memory: preload bytes and store items, big-endian across banks;
    // a load captures the addressed row of every bank.
    always_ff @(posedge clk)
    begin
        if (accept && in_data.req_type == REQ_PRELOAD && pl_addr < 32'(DATA_BYTES))
            mem_reg[pl_addr[1:0]][pl_addr[AddrBits-1:2]] <= in_data.load_byte;
        else if (do_store)
        begin
            if (size == 3'd4)
            begin
                mem_reg[0][row] <= b[31:24];
                mem_reg[1][row] <= b[23:16];
                mem_reg[2][row] <= b[15:8];
                mem_reg[3][row] <= b[7:0];
            end
            else if (size == 3'd2)
            begin
                mem_reg[{tgt[1], 1'b0}][row] <= b[15:8];
                mem_reg[{tgt[1], 1'b1}][row] <= b[7:0];
            end
            else
                mem_reg[tgt[1:0]][row] <= b[7:0];
        end
        if (ld_go)
        begin
            ld_word_reg <= {mem_reg[0][row], mem_reg[1][row], mem_reg[2][row],
                            mem_reg[3][row]};
            ld_op_reg   <= op;
            ld_lane_reg <= tgt[1:0];
            ld_rt_reg   <= rt;
        end
    end

    // Result register.
    out_item_t res;
    always_comb
    begin
        res = '0;
        res.next_pc  = pc_reg;
        res.hi_value = hi_reg;
        res.lo_value = lo_reg;
        res.halted   = stopped_reg;
        if (in_data.req_type == REQ_RESTART)
        begin
            res.next_pc = start_pc_reg;
            res.hi_value = 32'd0; res.lo_value = 32'd0; res.halted = 1'b0;
        end
        else if (in_data.req_type == REQ_EXEC && !stopped_reg)
        begin
            res.next_pc = npc;
            res.reg_changed = has_dest && gpr_reg[dest] != val;
            res.reg_index = res.reg_changed ? dest : 5'd0;
            res.reg_value = res.reg_changed ? val : 32'd0;
            if (mul)
            begin
                res.hi_value = prod[63:32];
                res.lo_value = prod[31:0];
            end
            res.err_write_zero = wz;
            res.err_overflow = ov;
            res.err_overwrite_hilo = ow;
            res.err_misaligned = (is_load || is_store) && op != OP_SPECIAL && mis;
            res.err_address = (is_load || is_store) && op != OP_SPECIAL && adr;
            res.halted = halt || fault;
        end
    end

    // Result valid: a load's result waits for its write-back.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            load_pend_reg <= 1'b0;
        end
        else
        begin
            load_pend_reg <= ld_go;
            if (load_pend_reg)
                out_valid_reg <= 1'b1;
            else if (accept)
                out_valid_reg <= !ld_go;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            out_reg <= res;
        else if (load_pend_reg)
        begin
            out_reg.reg_changed <= ld_changed;
            out_reg.reg_index   <= ld_changed ? ld_rt_reg : 5'd0;
            out_reg.reg_value   <= ld_changed ? ld_val : 32'd0;
        end
    end

    // Checks.
    a_gpr0_zero: assert property (@(posedge clk) disable iff (!rst_n)
        gpr_reg[0] == 32'd0) else $error("register zero changed");
    a_no_idx0: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.reg_changed |-> out_data.reg_index != 5'd0)
        else $error("change reported on register zero");
    a_stop_hold: assert property (@(posedge clk) disable iff (!rst_n)
        stopped_reg && !(accept && in_data.req_type == REQ_RESTART) |=> stopped_reg)
        else $error("stopped cleared without restart");
    a_pc_stopped: assert property (@(posedge clk) disable iff (!rst_n)
        stopped_reg && !(accept && in_data.req_type == REQ_RESTART) |=> $stable(pc_reg))
        else $error("pc moved while stopped");
    a_load_stall: assert property (@(posedge clk) disable iff (!rst_n)
        load_pend_reg |-> in_stall && !out_valid)
        else $error("item accepted while a load completes");

endmodule
`default_nettype wire

// ----- sim/mips_subset_instruction_executor_unit_tb.sv -----
// ----------------------------------------------------------------------------
// MIPS subset executor testbench
// Drives instruction, preload and restart items through the executor and
// compares every result with an in-bench architectural model of the core,
// across several start PC and stack pointer settings, with random idling on
// both sides of the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none
module mips_subset_instruction_executor_unit_tb;
    import msie_pkg::*;

    localparam int MEM_BYTES  = 1024;
    localparam int IDLE_LIMIT = 20000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    in_item_t    in_data;
    logic        out_valid;
    logic        out_stall;
    out_item_t   out_data;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [0:0]  cfg_index;
    logic [31:0] cfg_data;

    mips_subset_instruction_executor_unit #(.DATA_BYTES(MEM_BYTES)) uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // Architectural copy of the core.
    logic [31:0] arch_gpr [32];
    logic [31:0] arch_hi;
    logic [31:0] arch_lo;
    logic [31:0] arch_pc;
    logic        arch_unread;
    logic        arch_stopped;
    logic [7:0]  arch_mem [MEM_BYTES];
    bit          mem_written [MEM_BYTES];
    logic [31:0] set_start_pc;
    logic [31:0] set_init_sp;

    in_item_t  pending_items [$];
    out_item_t expected_results [$];
    int        mismatches;
    int        results_seen;

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic bit add_ovf(logic [31:0] a, logic [31:0] b, logic [31:0] r);
        return (((~(a ^ b)) & (a ^ r)) >> 31) != 0;
    endfunction

    function automatic bit signed_lt(logic [31:0] a, logic [31:0] b);
        return $signed(a) < $signed(b);
    endfunction

    function automatic int access_size(logic [5:0] op);
        if (op == OP_LW || op == OP_SW)
            return 4;
        if (op == OP_LH || op == OP_LHU || op == OP_SH)
            return 2;
        return 1;
    endfunction

    // Address check of a data access; returns 1 when the access goes ahead.
    function automatic bit addr_ok(logic [31:0] base, logic [31:0] off, int size,
                                   output logic [31:0] t, output bit ov,
                                   output bit mis, output bit adr);
        logic [32:0] last;
        bit          unaligned;
        t = base + off;
        ov = add_ovf(off, base, t);
        if (size > 1 && add_ovf(off, base, t + 32'(size) - 32'd1))
            ov = 1'b1;
        unaligned = (t & 32'(size - 1)) != 0;
        mis = 1'b0;
        adr = 1'b0;
        last = {1'b0, t} + 33'(size) - 33'd1;
        if (t[31] || last >= 33'(MEM_BYTES))
        begin
            adr = 1'b1;
            mis = unaligned;
            return 1'b0;
        end
        if (unaligned)
        begin
            mis = 1'b1;
            return 1'b0;
        end
        return 1'b1;
    endfunction

    // Works out the result of one item and advances the architectural state.
    task automatic predict_result(input in_item_t it, output out_item_t r);
        logic [31:0] w, a, b, val, pc4, npc, imm, simm, t, off;
        logic [5:0]  op, fn;
        logic [4:0]  rs, rt, rd, sh;
        logic signed [63:0] sp;
        logic [63:0] up;
        int          dest, size;
        bit          wz, ov, ow, mis, adr, take;
        wz = 0; ov = 0; ow = 0; mis = 0; adr = 0; take = 0;
        r = '0;
        if (it.req_type == REQ_PRELOAD)
        begin
            arch_mem[it.load_address] = it.load_byte;
            mem_written[it.load_address] = 1'b1;
        end
        else if (it.req_type == REQ_RESTART)
        begin
            for (int i = 0; i < 32; i++)
                arch_gpr[i] = '0;
            arch_gpr[REG_SP] = set_init_sp;
            arch_hi = '0;
            arch_lo = '0;
            arch_unread = 1'b0;
            arch_stopped = 1'b0;
            arch_pc = set_start_pc;
        end
        else if (it.req_type == REQ_EXEC && !arch_stopped)
        begin
            w = it.instr_word;
            op = w[31:26]; rs = w[25:21]; rt = w[20:16];
            rd = w[15:11]; sh = w[10:6]; fn = w[5:0];
            imm = {16'b0, w[15:0]};
            simm = {{16{w[15]}}, w[15:0]};
            a = arch_gpr[rs];
            b = arch_gpr[rt];
            pc4 = arch_pc + 32'd4;
            npc = pc4;
            dest = -1;
            val = '0;
            if (op == OP_HALT)
            begin
                arch_stopped = 1'b1;
                npc = arch_pc;
            end
            else if (op == OP_SPECIAL)
            begin
                case (fn)
                    FN_ADD:  begin val = a + b; ov = add_ovf(a, b, val); dest = rd; end
                    FN_ADDU: begin val = a + b; dest = rd; end
                    FN_SUB:
                    begin
                        val = a - b;
                        ov = (((a ^ b) & (a ^ val)) >> 31) != 0;
                        dest = rd;
                    end
                    FN_AND:  begin val = a & b; dest = rd; end
                    FN_OR:   begin val = a | b; dest = rd; end
                    FN_XOR:  begin val = a ^ b; dest = rd; end
                    FN_NOR:  begin val = ~(a | b); dest = rd; end
                    FN_NAND: begin val = ~(a & b); dest = rd; end
                    FN_SLT:  begin val = {31'b0, signed_lt(a, b)}; dest = rd; end
                    FN_SLL:
                    begin
                        if (!(sh == 0 && rd == 0))
                        begin
                            val = b << sh;
                            dest = rd;
                        end
                    end
                    FN_SRL:  begin val = b >> sh; dest = rd; end
                    FN_SRA:  begin val = $signed(b) >>> sh; dest = rd; end
                    FN_JR:   npc = a;
                    FN_MULT:
                    begin
                        sp = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
                        ow = arch_unread;
                        arch_hi = sp[63:32];
                        arch_lo = sp[31:0];
                        arch_unread = 1'b1;
                    end
                    FN_MULTU:
                    begin
                        up = {32'b0, a} * {32'b0, b};
                        ow = arch_unread;
                        arch_hi = up[63:32];
                        arch_lo = up[31:0];
                        arch_unread = 1'b1;
                    end
                    FN_MFHI: begin val = arch_hi; dest = rd; arch_unread = 1'b0; end
                    FN_MFLO: begin val = arch_lo; dest = rd; arch_unread = 1'b0; end
                    default: ;
                endcase
            end
            else
            begin
                case (op)
                    OP_ADDI:  begin val = a + simm; ov = add_ovf(a, simm, val); dest = rt; end
                    OP_ADDIU: begin val = a + simm; dest = rt; end
                    OP_LUI:   begin val = imm << 16; dest = rt; end
                    OP_ANDI:  begin val = a & imm; dest = rt; end
                    OP_ORI:   begin val = a | imm; dest = rt; end
                    OP_NORI:  begin val = ~(a | imm); dest = rt; end
                    OP_SLTI:  begin val = {31'b0, signed_lt(a, simm)}; dest = rt; end
                    OP_LW, OP_LH, OP_LHU, OP_LB, OP_LBU:
                    begin
                        size = access_size(op);
                        if (addr_ok(a, simm, size, t, ov, mis, adr))
                        begin
                            if (size == 4)
                                val = {arch_mem[t], arch_mem[t + 1], arch_mem[t + 2],
                                       arch_mem[t + 3]};
                            else if (size == 2)
                            begin
                                val = {16'b0, arch_mem[t], arch_mem[t + 1]};
                                if (op == OP_LH)
                                    val = {{16{val[15]}}, val[15:0]};
                            end
                            else
                            begin
                                val = {24'b0, arch_mem[t]};
                                if (op == OP_LB)
                                    val = {{24{val[7]}}, val[7:0]};
                            end
                            dest = rt;
                        end
                        else if (rt == 0)
                            wz = 1'b1;
                    end
                    OP_SW, OP_SH, OP_SB:
                    begin
                        size = access_size(op);
                        if (addr_ok(a, simm, size, t, ov, mis, adr))
                        begin
                            for (int k = 0; k < size; k++)
                            begin
                                arch_mem[t + k] = 8'(b >> (8 * (size - 1 - k)));
                                mem_written[t + k] = 1'b1;
                            end
                        end
                    end
                    OP_BEQ:  take = (a == b);
                    OP_BNE:  take = (a != b);
                    OP_BGTZ: take = signed_lt(32'd0, a);
                    OP_J:    npc = {pc4[31:28], w[25:0], 2'b00};
                    OP_JAL:
                    begin
                        val = pc4;
                        dest = REG_RA;
                        npc = {pc4[31:28], w[25:0], 2'b00};
                    end
                    default: ;
                endcase
                if (take)
                begin
                    off = simm << 2;
                    npc = pc4 + off;
                    if (add_ovf(pc4, off, npc))
                        ov = 1'b1;
                end
            end
            if (dest == 0)
                wz = 1'b1;
            else if (dest > 0)
            begin
                if (arch_gpr[dest] != val)
                begin
                    r.reg_changed = 1'b1;
                    r.reg_index = 5'(dest);
                    r.reg_value = val;
                end
                arch_gpr[dest] = val;
            end
            if (mis || adr)
                arch_stopped = 1'b1;
            arch_pc = npc;
        end
        r.next_pc = arch_pc;
        r.hi_value = arch_hi;
        r.lo_value = arch_lo;
        r.err_write_zero = wz;
        r.err_overflow = ov;
        r.err_overwrite_hilo = ow;
        r.err_misaligned = mis;
        r.err_address = adr;
        r.halted = arch_stopped;
    endtask

    task automatic queue_item(input in_item_t it);
        out_item_t r;
        predict_result(it, r);
        pending_items = {pending_items, it};
        expected_results = {expected_results, r};
    endtask

    // Queues an item; a load that would read bytes never written gets
    // preload items for those bytes first.
    task automatic send_item(input in_item_t it);
        logic [31:0] t;
        bit          ov, mis, adr;
        int          size;
        in_item_t    pl;
        if (it.req_type == REQ_EXEC && !arch_stopped &&
            (it.instr_word[31:26] inside {OP_LW, OP_LH, OP_LHU, OP_LB, OP_LBU}))
        begin
            size = access_size(it.instr_word[31:26]);
            if (addr_ok(arch_gpr[it.instr_word[25:21]], {{16{it.instr_word[15]}},
                        it.instr_word[15:0]}, size, t, ov, mis, adr))
            begin
                for (int k = 0; k < size; k++)
                begin
                    if (!mem_written[t + k])
                    begin
                        pl = '0;
                        pl.req_type = REQ_PRELOAD;
                        pl.instr_word = $urandom;
                        pl.load_address = 10'(t + 32'(k));
                        pl.load_byte = 8'($urandom);
                        queue_item(pl);
                    end
                end
            end
        end
        queue_item(it);
    endtask

    function automatic in_item_t exec_item(logic [31:0] w);
        in_item_t it;
        it.req_type = REQ_EXEC;
        it.instr_word = w;
        it.load_address = 10'($urandom);
        it.load_byte = 8'($urandom);
        return it;
    endfunction

    function automatic logic [31:0] rtype(logic [4:0] rs, logic [4:0] rt, logic [4:0] rd,
                                          logic [4:0] sh, logic [5:0] fn);
        return {OP_SPECIAL, rs, rt, rd, sh, fn};
    endfunction

    function automatic logic [31:0] itype(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
                                          logic [15:0] imm);
        return {op, rs, rt, imm};
    endfunction

    task automatic send_exec(input logic [31:0] w);
        send_item(exec_item(w));
    endtask

    task automatic send_restart();
        in_item_t it;
        it = exec_item($urandom);
        it.req_type = REQ_RESTART;
        send_item(it);
    endtask

    task automatic wait_drained();
        while (pending_items.size() != 0 || expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_setting(input logic [0:0] idx, input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
        if (idx == CFG_START_PC)
            set_start_pc = value;
        else
            set_init_sp = value;
    endtask

    // A short known sequence covering a selection of operations and corner cases.
    task automatic send_directed();
        in_item_t it;
        send_restart();
        send_exec(itype(OP_LUI, 5'd0, 5'd1, 16'h7FFF));
        send_exec(itype(OP_ORI, 5'd1, 5'd1, 16'hFFFF));
        send_exec(itype(OP_ADDI, 5'd0, 5'd2, 16'hFFFF));
        send_exec(rtype(5'd1, 5'd1, 5'd3, 5'd0, FN_ADD));
        send_exec(rtype(5'd2, 5'd1, 5'd4, 5'd0, FN_SUB));
        send_exec(rtype(5'd1, 5'd2, 5'd5, 5'd0, FN_SLT));
        send_exec(rtype(5'd0, 5'd0, 5'd0, 5'd0, FN_SLL));
        send_exec(rtype(5'd0, 5'd2, 5'd0, 5'd3, FN_SLL));
        send_exec(rtype(5'd0, 5'd2, 5'd6, 5'd0, FN_SRA));
        send_exec(rtype(5'd0, 5'd2, 5'd7, 5'd31, FN_SRA));
        send_exec(rtype(5'd1, 5'd2, 5'd0, 5'd0, FN_MULT));
        send_exec(rtype(5'd2, 5'd2, 5'd0, 5'd0, FN_MULTU));
        send_exec(rtype(5'd0, 5'd0, 5'd8, 5'd0, FN_MFHI));
        send_exec(rtype(5'd0, 5'd0, 5'd9, 5'd0, FN_MFLO));
        send_exec(itype(OP_ADDI, 5'd1, 5'd0, 16'h0001));
        send_exec(itype(OP_SB, 5'd0, 5'd2, 16'd5));
        send_exec(itype(OP_LB, 5'd0, 5'd10, 16'd5));
        send_exec(itype(OP_BGTZ, 5'd1, 5'd0, 16'h8000));
        send_exec(itype(OP_BNE, 5'd1, 5'd2, 16'hFFFE));
        send_exec({OP_JAL, 26'h3FFFFFF});
        send_exec(itype(OP_LHU, 5'd0, 5'd11, 16'd1023));
        send_exec(itype(OP_LW, 5'd0, 5'd11, 16'd4));
        it = exec_item($urandom);
        it.req_type = REQ_NONE;
        send_item(it);
        send_restart();
        send_exec({OP_HALT, 26'h0});
        send_exec(rtype(5'd1, 5'd1, 5'd3, 5'd0, FN_ADDU));
    endtask

    // Mostly well-formed instructions on working registers 0 to 7, mixed with restart, preload and none items.
    task automatic send_random_item();
        int          pick, size, target;
        logic [4:0]  rs, rt, rd;
        logic [5:0]  op, fn;
        logic [31:0] off;
        in_item_t    it;
        logic [5:0]  ops_mem [8] = '{OP_LW, OP_LH, OP_LHU, OP_LB, OP_LBU, OP_SW, OP_SH, OP_SB};
        logic [5:0]  ops_imm [10] = '{OP_ADDI, OP_ADDIU, OP_LUI, OP_ANDI, OP_ORI, OP_NORI,
                                      OP_SLTI, OP_BEQ, OP_BNE, OP_BGTZ};
        logic [5:0]  fns [17] = '{FN_ADD, FN_ADDU, FN_SUB, FN_AND, FN_OR, FN_XOR, FN_NOR,
                                  FN_NAND, FN_SLT, FN_SLL, FN_SRL, FN_SRA, FN_JR, FN_MULT,
                                  FN_MULTU, FN_MFHI, FN_MFLO};
        if (arch_stopped && $urandom_range(0, 3) != 0)
        begin
            send_restart();
            return;
        end
        pick = $urandom_range(0, 99);
        rs = 5'($urandom_range(0, 7));
        rt = 5'($urandom_range(0, 7));
        rd = 5'($urandom_range(0, 7));
        if (pick < 30)
        begin
            op = ops_mem[$urandom_range(0, 7)];
            size = access_size(op);
            target = $urandom_range(0, MEM_BYTES - 1);
            if ($urandom_range(0, 9) != 0)
                target = target & ~(size - 1);
            off = 32'(target) - arch_gpr[rs];
            if ($signed(off) < -32768 || $signed(off) > 32767)
            begin
                rs = 5'd0;
                off = 32'(target);
            end
            if ($urandom_range(0, 19) == 0)
                off = $urandom;
            send_exec(itype(op, rs, rt, off[15:0]));
        end
        else if (pick < 60)
        begin
            fn = fns[$urandom_range(0, 16)];
            send_exec(rtype(rs, rt, rd, 5'($urandom), fn));
        end
        else if (pick < 85)
        begin
            op = ops_imm[$urandom_range(0, 9)];
            send_exec(itype(op, rs, rt, 16'($urandom)));
        end
        else if (pick < 88)
            send_exec({($urandom_range(0, 1) != 0) ? OP_J : OP_JAL, 26'($urandom)});
        else if (pick < 89)
            send_exec({OP_HALT, 26'($urandom)});
        else if (pick < 91)
            send_restart();
        else if (pick < 94)
        begin
            it = exec_item($urandom);
            it.req_type = REQ_PRELOAD;
            send_item(it);
        end
        else if (pick < 96)
        begin
            it = exec_item($urandom);
            it.req_type = REQ_NONE;
            send_item(it);
        end
        else
            send_exec($urandom);
    endtask

    // Stimulus: phases of settings, each opened by a restart.
    initial
    begin
        logic [31:0] pcs [4];
        logic [31:0] sps [4];
        mismatches = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        for (int i = 0; i < 32; i++)
            arch_gpr[i] = '0;
        for (int i = 0; i < MEM_BYTES; i++)
        begin
            arch_mem[i] = '0;
            mem_written[i] = 1'b0;
        end
        arch_hi = '0; arch_lo = '0; arch_pc = '0;
        arch_unread = 1'b0; arch_stopped = 1'b0;
        set_start_pc = '0; set_init_sp = '0;
        pcs = '{32'h0, 32'hFFFF_FFFF, $urandom, 32'h0040_0000};
        sps = '{32'h0, 32'hFFFF_FFFF, $urandom, 32'h0000_03FC};
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int ph = 0; ph < 4; ph++)
        begin
            write_setting(CFG_START_PC, pcs[ph]);
            write_setting(CFG_INIT_SP, sps[ph]);
            if (ph == 0)
                send_directed();
            send_restart();
            for (int n = 0; n < 250; n++)
                send_random_item();
            wait_drained();
        end
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Sender: bursts of random length separated by random gaps.
    int burst_left;
    int gap_left;
    initial
    begin
        burst_left = 0;
        gap_left = 0;
    end

    always @(posedge clk)
    begin
        if (rst_n && !(in_valid && in_stall))
        begin
            if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                in_valid <= 1'b0;
            end
            else if (pending_items.size() != 0)
            begin
                in_valid <= 1'b1;
                in_data <= pending_items.pop_front();
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got, inout bit bad);
        if (want !== got)
        begin
            if (!bad && mismatches < 10)
                $display("result %0d mismatch:", results_seen);
            if (mismatches < 10)
                $display("  %s expected %h actual %h", name, want, got);
            bad = 1'b1;
        end
    endtask

    // Receiver: compares each result and stalls on its own pattern, with one
    // long hold-off while the sender keeps offering.
    int stall_pct;
    int pattern_left;
    int hold_left;
    bit hold_done;
    initial
    begin
        results_seen = 0;
        stall_pct = 0;
        pattern_left = 0;
        hold_left = 0;
        hold_done = 1'b0;
        out_stall = 1'b0;
    end

    always @(posedge clk)
    begin
        out_item_t want;
        bit        bad;
        if (out_valid && !out_stall)
        begin
            results_seen <= results_seen + 1;
            if (expected_results.size() == 0)
            begin
                if (mismatches < 10)
                    $display("unexpected result %0d: %p", results_seen, out_data);
                mismatches <= mismatches + 1;
            end
            else
            begin
                want = expected_results.pop_front();
                bad = 1'b0;
                check_field("next_pc", want.next_pc, out_data.next_pc, bad);
                check_field("reg_changed", want.reg_changed, out_data.reg_changed, bad);
                check_field("reg_index", want.reg_index, out_data.reg_index, bad);
                check_field("reg_value", want.reg_value, out_data.reg_value, bad);
                check_field("hi_value", want.hi_value, out_data.hi_value, bad);
                check_field("lo_value", want.lo_value, out_data.lo_value, bad);
                check_field("err_write_zero", want.err_write_zero,
                            out_data.err_write_zero, bad);
                check_field("err_overflow", want.err_overflow, out_data.err_overflow, bad);
                check_field("err_overwrite_hilo", want.err_overwrite_hilo,
                            out_data.err_overwrite_hilo, bad);
                check_field("err_misaligned", want.err_misaligned,
                            out_data.err_misaligned, bad);
                check_field("err_address", want.err_address, out_data.err_address, bad);
                check_field("halted", want.halted, out_data.halted, bad);
                if (bad)
                    mismatches <= mismatches + 1;
            end
        end
        if (!hold_done && results_seen == 400)
        begin
            hold_done <= 1'b1;
            hold_left <= 300;
            out_stall <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            if (pattern_left == 0)
            begin
                pattern_left <= $urandom_range(16, 96);
                stall_pct <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 80);
            end
            else
                pattern_left <= pattern_left - 1;
            out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // Watchdog: ends the run if no item moves on any channel for too long.
    int idle_cycles;
    initial idle_cycles = 0;

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

endmodule
`default_nettype wire

// ----- mips_subset_instruction_executor_unit.f -----
design/msie_pkg.sv
design/mips_subset_instruction_executor_unit.sv
sim/mips_subset_instruction_executor_unit_tb.sv
